/* rtl/keypad_matrix_scan_iir_filter_defines.svh */
// Assertion macros for the key matrix scan filter.
// No dependencies; taken in by the top level.
`ifndef KEYPAD_MATRIX_SCAN_IIR_FILTER_DEFINES_SVH
`define KEYPAD_MATRIX_SCAN_IIR_FILTER_DEFINES_SVH

`ifndef SYNTH
// Clocked check, muted while reset is asserted.
`define KMSIF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Clocked check that also holds through reset.
`define KMSIF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define KMSIF_ASSERT(label, prop, msg)
`define KMSIF_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

/* rtl/kmsif_pkg.sv */
// Shared constants and helpers for the key matrix scan filter.
// No dependencies.
package kmsif_pkg;

  localparam int DEF_COLUMNS   = 8;
  localparam int DEF_ROWS      = 8;

  // Averaging length is a power of two, so the divide is a shift.
  localparam int FILTER_SHIFT  = 3;
  localparam int FILTER_LENGTH = 1 << FILTER_SHIFT;

  localparam int SAMPLE_W = 12;
  localparam int LEVEL_W  = 16;
  localparam int POS_W    = 3;
  localparam int FRAME_W  = 32;
  localparam int SUM_W    = LEVEL_W + 1;
  localparam int ACC_W    = LEVEL_W + FILTER_SHIFT;

  // (r << 4) + (r >> 8): the low nibble of r << 4 is zero, so this is a concatenation.
  function automatic logic [LEVEL_W-1:0] widen_reading(input logic [SAMPLE_W-1:0] r);
    return {r, r[SAMPLE_W-1 -: 4]};
  endfunction

endpackage

/* rtl/keypad_matrix_scan_iir_filter.sv */
// Key matrix scanner with a per-key recursive (IIR) averaging filter held in a local RAM.
// Depends on kmsif_pkg and keypad_matrix_scan_iir_filter_defines.svh.
//
// Usage:
//   Input channel (in_valid/in_ready): one transaction per key visit, carrying two
//   12-bit converter readings for the key at the current scan position. Positions
//   run column-major: row advances on every transaction, column when the row wraps.
//   Output channel (out_valid/out_ready): exactly one transaction per input, giving
//   the column and row visited (low 3 bits), the key's new filtered level
//   (old*6 + a + b)/8, the completed-frame count including this visit, and a flag
//   on the last key of a scan.
//   Throughput: one transaction per cycle sustained while out_ready stays high. The
//   accepting edge loads the RAM-read stage and reads the level RAM (synchronous read);
//   when that stage moves on, the new level is written back and into the output register.
//   Back-to-back visits to the same key (single-key matrix) are forwarded from the
//   write-back path, so the RAM never returns a stale level.
//   Reset (rst_n low, synchronous) returns the scan to column 0 / row 0, clears the
//   frame counter and the per-key valid flags, so every key reads as zero; no
//   clearing pass is needed and input is accepted straight after reset.
//   When the receiver stalls, the result waits in the output register while one
//   further transaction may sit in the RAM-read stage; only then does in_ready drop.
module keypad_matrix_scan_iir_filter #(
  parameter int COLUMNS = kmsif_pkg::DEF_COLUMNS,
  parameter int ROWS    = kmsif_pkg::DEF_ROWS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [kmsif_pkg::SAMPLE_W-1:0]   in_sample_first,
  input  logic [kmsif_pkg::SAMPLE_W-1:0]   in_sample_second,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [kmsif_pkg::POS_W-1:0]      out_drive_column,
  output logic [kmsif_pkg::POS_W-1:0]      out_sense_row,
  output logic [kmsif_pkg::LEVEL_W-1:0]    out_filtered_level,
  output logic [kmsif_pkg::FRAME_W-1:0]    out_frame_count,
  output logic                             out_frame_end
);

`include "keypad_matrix_scan_iir_filter_defines.svh"

  localparam int KEY_COUNT = COLUMNS * ROWS;
  localparam int CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int IW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam int LW = kmsif_pkg::LEVEL_W;
  localparam int AW = kmsif_pkg::ACC_W;
  localparam int FW = kmsif_pkg::FRAME_W;

  // ---------------- scan position and frame counter ----------------
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [IW-1:0] key_idx_r, key_idx_nxt;   // linear address col*ROWS + row
  logic [FW-1:0] frames_r, frames_nxt;
  logic          row_last, col_last, scan_last;

  // ---------------- RAM-read stage ----------------
  logic                        s1_valid_r;
  logic [CW-1:0]               s1_col_r;
  logic [RW-1:0]               s1_row_r;
  logic [IW-1:0]               s1_idx_r;
  logic [kmsif_pkg::SUM_W-1:0] s1_sum_r;
  logic [FW-1:0]               s1_frames_r;
  logic                        s1_last_r;
  logic                        s1_adv;

  // ---------------- level store ----------------
  logic [LW-1:0]        key_mem [KEY_COUNT];
  logic [KEY_COUNT-1:0] key_valid_r;      // cleared at reset; unwritten keys read zero
  logic [LW-1:0]        mem_rdata_r;
  logic                 rd_valid_r;
  logic                 fwd_valid_r;
  logic [LW-1:0]        fwd_data_r;
  logic                 fwd_hit;

  // ---------------- filter arithmetic ----------------
  logic [LW-1:0] old_level;
  logic [AW-1:0] acc;
  logic [LW-1:0] level_nxt;

  // ---------------- output register ----------------
  logic          out_valid_r;
  logic [CW-1:0] out_col_r;
  logic [RW-1:0] out_row_r;
  logic [LW-1:0] out_level_r;
  logic [FW-1:0] out_frames_r;
  logic          out_last_r;

  logic in_accept;
  logic [kmsif_pkg::SUM_W-1:0] sample_sum;

  // Handshake: stage 1 moves on whenever the output register is free or draining.
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_adv;
  assign in_accept = in_valid && in_ready;

  // Scan position advance
  assign row_last  = (row_r == RW'(ROWS - 1));
  assign col_last  = (col_r == CW'(COLUMNS - 1));
  assign scan_last = row_last && col_last;

  always_comb begin
    row_nxt     = row_last ? '0 : row_r + RW'(1);
    col_nxt     = row_last ? (col_last ? '0 : col_r + CW'(1)) : col_r;
    key_idx_nxt = scan_last ? '0 : key_idx_r + IW'(1);
    frames_nxt  = scan_last ? frames_r + FW'(1) : frames_r;
  end

  assign sample_sum = kmsif_pkg::SUM_W'(kmsif_pkg::widen_reading(in_sample_first))
                    + kmsif_pkg::SUM_W'(kmsif_pkg::widen_reading(in_sample_second));

  // Write in this cycle to the key being read: take the new level directly.
  assign fwd_hit = s1_adv && (s1_idx_r == key_idx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      key_idx_r  <= '0;
      frames_r   <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        col_r      <= col_nxt;
        row_r      <= row_nxt;
        key_idx_r  <= key_idx_nxt;
        frames_r   <= frames_nxt;
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  // Stage-1 payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_col_r    <= col_r;
      s1_row_r    <= row_r;
      s1_idx_r    <= key_idx_r;
      s1_sum_r    <= sample_sum;
      s1_frames_r <= frames_nxt;
      s1_last_r   <= scan_last;
      rd_valid_r  <= key_valid_r[key_idx_r];
      fwd_valid_r <= fwd_hit;
      fwd_data_r  <= level_nxt;
    end
  end

  // Level RAM: one read port, one write port
  always_ff @(posedge clk) begin
    if (in_accept) begin
      mem_rdata_r <= key_mem[key_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      key_mem[s1_idx_r] <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_valid_r <= '0;
    end else if (s1_adv) begin
      key_valid_r[s1_idx_r] <= 1'b1;
    end
  end

  // Filter: (old*(L-2) + a + b) / L
  always_comb begin
    if (fwd_valid_r) begin
      old_level = fwd_data_r;
    end else if (rd_valid_r) begin
      old_level = mem_rdata_r;
    end else begin
      old_level = '0;
    end
    acc       = AW'(old_level) * AW'(kmsif_pkg::FILTER_LENGTH - 2) + AW'(s1_sum_r);
    level_nxt = acc[AW-1 -: LW];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_col_r    <= s1_col_r;
      out_row_r    <= s1_row_r;
      out_level_r  <= level_nxt;
      out_frames_r <= s1_frames_r;
      out_last_r   <= s1_last_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_drive_column   = kmsif_pkg::POS_W'(out_col_r);
  assign out_sense_row      = kmsif_pkg::POS_W'(out_row_r);
  assign out_filtered_level = out_level_r;
  assign out_frame_count    = out_frames_r;
  assign out_frame_end      = out_last_r;

  // ---------------- assertions ----------------
  `KMSIF_ASSERT(a_idx_track,
    32'(key_idx_r) == 32'(col_r) * 32'(ROWS) + 32'(row_r),
    "scan address out of step with column and row")
  `KMSIF_ASSERT(a_frame_hold,
    in_accept && !scan_last |=> frames_r == $past(frames_r),
    "frame counter moved away from the end of a scan")
  `KMSIF_ASSERT(a_end_pos,
    out_valid && out_frame_end |->
      out_sense_row == kmsif_pkg::POS_W'(ROWS - 1) &&
      out_drive_column == kmsif_pkg::POS_W'(COLUMNS - 1),
    "frame end flagged away from the last key")
  `KMSIF_ASSERT(a_stall_block,
    s1_valid_r && !s1_adv |=> $stable(s1_idx_r) && $stable(s1_sum_r),
    "read stage overwritten while stalled")

endmodule

/* tb/keypad_matrix_scan_iir_filter_test.sv */
// Self-checking testbench for the key matrix scanner with per-key recursive (IIR) averaging filter.
// Depends on kmsif_pkg and the keypad_matrix_scan_iir_filter RTL; needs no other files.
module keypad_matrix_scan_iir_filter_test;

  // Default 8 x 8 matrix, as the block is built by default.
  localparam int MATRIX_COLUMNS   = kmsif_pkg::DEF_COLUMNS;
  localparam int MATRIX_ROWS      = kmsif_pkg::DEF_ROWS;
  localparam int KEY_TOTAL        = MATRIX_COLUMNS * MATRIX_ROWS;
  localparam int KEY_IW           = (KEY_TOTAL > 1) ? $clog2(KEY_TOTAL) : 1;
  // Run guard: far beyond the slowest legal run (about 500 transactions, each with
  // idle cycles in front and a stalled receiver behind).
  localparam int CYCLE_LIMIT      = 400000;
  // Margin after every expected result is back, at the end of each phase.
  localparam int SETTLE_CYCLES    = 8;
  localparam int LONG_HOLD_CYCLES = 64;
  localparam int MAX_SENDER_GAP   = 40;
  localparam logic [kmsif_pkg::SAMPLE_W-1:0] READING_MAX = '1;

  // One result transaction, field for field.
  typedef struct packed {
    logic [kmsif_pkg::POS_W-1:0]   column;
    logic [kmsif_pkg::POS_W-1:0]   row;
    logic [kmsif_pkg::LEVEL_W-1:0] level;
    logic [kmsif_pkg::FRAME_W-1:0] frames;
    logic                          frame_end;
  } key_visit_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [kmsif_pkg::SAMPLE_W-1:0] in_sample_first = '0;
  logic [kmsif_pkg::SAMPLE_W-1:0] in_sample_second = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [kmsif_pkg::POS_W-1:0]    out_drive_column;
  logic [kmsif_pkg::POS_W-1:0]    out_sense_row;
  logic [kmsif_pkg::LEVEL_W-1:0]  out_filtered_level;
  logic [kmsif_pkg::FRAME_W-1:0]  out_frame_count;
  logic                           out_frame_end;

  keypad_matrix_scan_iir_filter #(
    .COLUMNS (MATRIX_COLUMNS),
    .ROWS    (MATRIX_ROWS)
  ) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_sample_first    (in_sample_first),
    .in_sample_second   (in_sample_second),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_drive_column   (out_drive_column),
    .out_sense_row      (out_sense_row),
    .out_filtered_level (out_filtered_level),
    .out_frame_count    (out_frame_count),
    .out_frame_end      (out_frame_end)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 0;
  end

  // ---------------------------------------------------------------------------
  // Scan predictor: own copy of the key levels, scan position and frame counter.
  // Starts at the reset state; reset is applied only once.
  // ---------------------------------------------------------------------------
  logic [kmsif_pkg::LEVEL_W-1:0] key_level_copy [KEY_TOTAL];
  int unsigned                   scan_column_copy = 0;
  int unsigned                   scan_row_copy = 0;
  logic [kmsif_pkg::FRAME_W-1:0] frames_copy = '0;
  key_visit_t                    expected_visits [$];

  int unsigned        mismatches = 0;
  int unsigned        cycle_count = 0;
  int unsigned        sender_idle_pct = 0;
  int unsigned        receiver_stall_pct = 0;
  int unsigned        hold_requests = 0;
  int unsigned        holds_started = 0;
  int unsigned        hold_left = 0;

  // 12-bit reading stretched to full 16-bit scale: r * 16 + top nibble of r.
  function automatic logic [kmsif_pkg::LEVEL_W-1:0] stretch_reading(
      input logic [kmsif_pkg::SAMPLE_W-1:0] r);
    logic [kmsif_pkg::LEVEL_W-1:0] wide;
    wide = kmsif_pkg::LEVEL_W'(r);
    return (wide << 4) + (wide >> 8);
  endfunction

  // Filter update for the key at the current position, then advance the scan.
  function automatic void predict_key_visit(input logic [kmsif_pkg::SAMPLE_W-1:0] first,
                                            input logic [kmsif_pkg::SAMPLE_W-1:0] second);
    logic [KEY_IW-1:0] key;
    int unsigned       acc;
    key_visit_t        visit;
    key = KEY_IW'(scan_column_copy * MATRIX_ROWS + scan_row_copy);
    // old * (N - 2) + a + b stays below 2^19, so 32 bits never overflow.
    acc = int'(key_level_copy[key]) * (kmsif_pkg::FILTER_LENGTH - 2)
        + int'(stretch_reading(first)) + int'(stretch_reading(second));
    visit.level     = kmsif_pkg::LEVEL_W'(acc / kmsif_pkg::FILTER_LENGTH);
    visit.column    = kmsif_pkg::POS_W'(scan_column_copy);
    visit.row       = kmsif_pkg::POS_W'(scan_row_copy);
    visit.frame_end = (scan_row_copy == MATRIX_ROWS - 1) &&
                      (scan_column_copy == MATRIX_COLUMNS - 1);
    key_level_copy[key] = visit.level;
    // Column-major: row moves every visit, column when the row wraps.
    if (scan_row_copy + 1 >= MATRIX_ROWS) begin
      scan_row_copy    = 0;
      scan_column_copy = (scan_column_copy + 1 >= MATRIX_COLUMNS) ? 0 : scan_column_copy + 1;
    end else begin
      scan_row_copy = scan_row_copy + 1;
    end
    // Frame count already includes the frame this visit closes.
    if (visit.frame_end) begin
      frames_copy = frames_copy + 1'b1;
    end
    visit.frames = frames_copy;
    expected_visits.push_back(visit);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: one transaction per call. Called at a rising edge; a random run of
  // idle cycles goes in front, then valid is held until in_ready is seen.
  // Valid is only lowered when a gap follows, so it never drops and rises in one step.
  // ---------------------------------------------------------------------------
  task automatic send_visit(input logic [kmsif_pkg::SAMPLE_W-1:0] first,
                            input logic [kmsif_pkg::SAMPLE_W-1:0] second);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct && gap < MAX_SENDER_GAP) begin
      gap++;
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_sample_first  <= first;
    in_sample_second <= second;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_key_visit(first, second);
  endtask

  // Stop offering and let every outstanding result come back before moving on.
  task automatic finish_phase();
    in_valid <= 1'b0;
    while (expected_visits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mix of corner readings, walking ones and zeros, near-full-scale values and plain uniform values.
  function automatic logic [kmsif_pkg::SAMPLE_W-1:0] pick_reading();
    logic [kmsif_pkg::SAMPLE_W-1:0] one_hot;
    one_hot = kmsif_pkg::SAMPLE_W'(1) << $urandom_range(kmsif_pkg::SAMPLE_W - 1);
    case ($urandom_range(9))
      0:       return '0;
      1:       return READING_MAX;
      2:       return one_hot;
      3:       return ~one_hot;
      4:       return kmsif_pkg::SAMPLE_W'($urandom_range(4095, 3840));
      default: return kmsif_pkg::SAMPLE_W'($urandom_range(4095));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random stalls at the phase's rate, or a long counted hold-off when
  // a test asks for one.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (holds_started != hold_requests) begin
      holds_started++;
      hold_left = LONG_HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result against the oldest expectation.
  // Outputs are read at the edge, before the block's own updates land.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    key_visit_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_visits.size() == 0) begin
        $error("unexpected result transaction: column %0d row %0d level %0d",
               out_drive_column, out_sense_row, out_filtered_level);
        mismatches++;
      end else begin
        want = expected_visits.pop_front();
        if (out_drive_column !== want.column) begin
          $error("drive_column: expected %0d, got %0d", want.column, out_drive_column);
          mismatches++;
        end
        if (out_sense_row !== want.row) begin
          $error("sense_row: expected %0d, got %0d", want.row, out_sense_row);
          mismatches++;
        end
        if (out_filtered_level !== want.level) begin
          $error("filtered_level: expected %0d, got %0d", want.level, out_filtered_level);
          mismatches++;
        end
        if (out_frame_count !== want.frames) begin
          $error("frame_count: expected %0d, got %0d", want.frames, out_frame_count);
          mismatches++;
        end
        if (out_frame_end !== want.frame_end) begin
          $error("frame_end: expected %0d, got %0d", want.frame_end, out_frame_end);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: a hung handshake or a lost result ends here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Corner readings on the first keys after reset: all zero, full scale, one side
  // full, mid scale, nibble boundaries of the stretch, alternating bit patterns.
  task automatic test_directed_extremes();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    send_visit(12'h000, 12'h000);
    send_visit(12'hFFF, 12'hFFF);
    send_visit(12'hFFF, 12'h000);
    send_visit(12'h000, 12'hFFF);
    send_visit(12'h800, 12'h800);
    send_visit(12'h0FF, 12'h100);
    send_visit(12'h100, 12'h0FF);
    send_visit(12'hAAA, 12'h555);
    send_visit(12'h555, 12'hAAA);
    send_visit(12'h001, 12'hFFE);
    send_visit(12'h7FF, 12'h7FF);
    send_visit(12'hF00, 12'h00F);
    send_visit(12'hFFF, 12'hFFF);
    send_visit(12'hFFF, 12'hFFF);
    send_visit(12'hFFF, 12'hFFF);
    send_visit(12'hFFF, 12'hFFF);
    // More readings with a slow receiver so results back up behind each other.
    receiver_stall_pct = 50;
    send_visit(12'h000, 12'h001);
    send_visit(12'h0F0, 12'h0F0);
    send_visit(12'hFFF, 12'hFFE);
    send_visit(12'h123, 12'hEDC);
    finish_phase();
  endtask

  // Random readings under one idling pattern; several phases walk the scan through
  // multiple frames and across frame ends.
  task automatic test_random_traffic(input int unsigned idle_pct,
                                     input int unsigned stall_pct,
                                     input int unsigned visits);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (visits) begin
      send_visit(pick_reading(), pick_reading());
    end
    finish_phase();
  endtask

  // Two full frames pressed hard on every key, pushing levels towards the ceiling,
  // while the receiver holds off long enough to fill the block and stall its input.
  task automatic test_full_press_backpressure();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_requests++;
    repeat (2 * KEY_TOTAL) begin
      send_visit(READING_MAX, ($urandom_range(3) == 0) ? pick_reading() : READING_MAX);
    end
    finish_phase();
  endtask

  initial begin
    for (int k = 0; k < KEY_TOTAL; k++) begin
      key_level_copy[KEY_IW'(k)] = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_extremes();
    test_random_traffic(0, 0, 95);
    test_random_traffic(71, 0, 95);
    test_random_traffic(0, 71, 95);
    test_random_traffic(15, 15, 95);
    test_full_press_backpressure();

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
